// ===== sv/eps_pkg.sv =====
`timescale 1ns / 1ps
// Package of the ephemeris pool selector: codes, constants and the structs
// passed between the sequencer and the row of record cells. No dependencies.
package eps_pkg;

  // Field widths of the stored record and of the result
  localparam int unsigned ABS_W  = 33;  // absolute seconds since week zero
  localparam int unsigned AGE_W  = 31;  // saturated age
  localparam int unsigned IDX_W  = 6;   // reported entry index
  localparam int unsigned PROD_W = 61;  // shared multiplier product
  localparam int unsigned QUOT_W = 21;  // millis / 1000

  // Time constants
  localparam logic [AGE_W-1:0] WEEK_SECONDS = 31'd604800;
  localparam logic [AGE_W-1:0] AGE_LIMIT    = 31'd7200;
  localparam logic [AGE_W-1:0] AGE_MAX      = 31'h7FFF_FFFF;
  // ceil(2^40 / 1000): floor(x * RECIP_MILLIS / 2^40) == x / 1000 for x < 2^30
  localparam logic [AGE_W-1:0] RECIP_MILLIS = 31'd1099511628;
  localparam int unsigned      RECIP_SHIFT  = 40;

  localparam logic [1:0] SYS_UNSUPPORTED = 2'd3;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_NONE     = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_WEEK,
    S_SUM,
    S_EXEC,
    S_SCAN,
    S_FINISH
  } state_e;

  // Running best record, handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             found;
    logic             pref;
    logic [IDX_W-1:0] idx;
    logic [AGE_W-1:0] age;
  } token_t;

  // Query broadcast to all cells, held during a scan
  typedef struct packed {
    logic [1:0]       sys;
    logic [5:0]       sat;
    logic [ABS_W-1:0] qabs;
    logic [7:0]       src;
    logic             ignore;
  } query_t;

  // Record write into the cell at the fill position
  typedef struct packed {
    logic             en;
    logic [1:0]       sys;
    logic [5:0]       sat;
    logic [ABS_W-1:0] rabs;
    logic             unhealthy;
    logic [7:0]       src;
  } wr_t;

endpackage

// ===== sv/eps_cell.sv =====
`timescale 1ns / 1ps
// One record cell of the pool: holds a record and updates the best-record
// token as it passes by. Depends on eps_pkg.
module eps_cell import eps_pkg::*; #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned COUNT_W  = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [COUNT_W-1:0] count_i,
  input  wr_t                wr_i,
  input  query_t             query_i,
  input  token_t             tok_i,
  output token_t             tok_o
);

  localparam logic [COUNT_W-1:0] MY_POS = COUNT_W'(CELL_IDX);
  localparam logic [IDX_W-1:0]   MY_TAG = IDX_W'(CELL_IDX % 64);

  logic [1:0]       sys_q;
  logic [5:0]       sat_q;
  logic [ABS_W-1:0] rabs_q;
  logic             unh_q;
  logic [7:0]       src_q;
  token_t           tok_d, tok_q;

  logic             active, match, in_limit, pref, take;
  logic [ABS_W:0]   diff, mag;
  logic [AGE_W-1:0] age;

  // Record storage, written once at the fill position
  always_ff @(posedge clk_i) begin
    if (wr_i.en && count_i == MY_POS) begin
      sys_q  <= wr_i.sys;
      sat_q  <= wr_i.sat;
      rabs_q <= wr_i.rabs;
      unh_q  <= wr_i.unhealthy;
      src_q  <= wr_i.src;
    end
  end

  // Absolute difference, saturated
  always_comb begin
    diff = {1'b0, query_i.qabs} - {1'b0, rabs_q};
    mag  = diff[ABS_W] ? ((ABS_W+1)'(0) - diff) : diff;
    age  = (|mag[ABS_W:AGE_W]) ? AGE_MAX : mag[AGE_W-1:0];
  end

  // Candidate test and preference
  always_comb begin
    active   = count_i > MY_POS;
    match    = active && !unh_q && sys_q == query_i.sys && sat_q == query_i.sat;
    in_limit = query_i.ignore || age <= AGE_LIMIT;
    pref     = src_q == query_i.src;
    if (!tok_i.found) begin
      take = 1'b1;
    end else if (pref != tok_i.pref) begin
      take = pref;
    end else begin
      take = age < tok_i.age;
    end
    tok_d = tok_i;
    if (tok_i.valid && match && in_limit && take) begin
      tok_d.found = 1'b1;
      tok_d.pref  = pref;
      tok_d.idx   = MY_TAG;
      tok_d.age   = age;
    end
  end

  // Token stage toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== sv/eps_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the ephemeris pool: beat capture, time conversion on a shared
// multiplier, fill count, token launch and result register. Depends on eps_pkg.
module eps_ctrl import eps_pkg::*; #(
  parameter int unsigned POOL_DEPTH = 64,
  parameter int unsigned COUNT_W    = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [87:0]        s_axis_tdata,
  input  logic [0:0]         s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [39:0]        m_axis_tdata,
  output logic [1:0]         m_axis_tuser,
  output logic [COUNT_W-1:0] count_o,
  output wr_t                wr_o,
  output query_t             query_o,
  output token_t             launch_o,
  input  token_t             tok_end_i
);

  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(POOL_DEPTH);

  state_e state_q, state_d;

  // Captured beat
  op_e         op_q;
  logic [1:0]  sys_q;
  logic [5:0]  sat_q;
  logic [12:0] week_q;
  logic [19:0] ref_q;
  logic [29:0] qms_q;
  logic        unh_q;
  logic [7:0]  src_q;
  logic        ign_q;

  logic [PROD_W-1:0] prod_q;
  logic [QUOT_W-1:0] quot_q;
  logic [ABS_W-1:0]  abs_q;
  logic [29:0]       mul_a;
  logic [AGE_W-1:0]  mul_b;

  logic [COUNT_W-1:0] count_q, count_d;

  status_e          res_status_q;
  logic [IDX_W-1:0] res_idx_q;
  logic [AGE_W-1:0] res_age_q;

  logic             out_valid_q;
  status_e          out_status_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [AGE_W-1:0] out_age_q;

  logic in_fire, out_free, launch, do_write, pool_full;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign pool_full = count_q >= FULL_COUNT;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_fire) state_d = S_DIV;
      S_DIV:    state_d = S_WEEK;
      S_WEEK:   state_d = S_SUM;
      S_SUM:    state_d = S_EXEC;
      S_EXEC: begin
        if (op_q == OP_QUERY && sys_q != SYS_UNSUPPORTED) state_d = S_SCAN;
        else state_d = S_FINISH;
      end
      S_SCAN:   if (tok_end_i.valid) state_d = S_FINISH;
      S_FINISH: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_axis_tready = 1'b0;
    launch        = 1'b0;
    do_write      = 1'b0;
    mul_a         = qms_q;
    mul_b         = RECIP_MILLIS;
    case (state_q)
      S_IDLE:  s_axis_tready = 1'b1;
      S_WEEK: begin
        mul_a = 30'(week_q);
        mul_b = WEEK_SECONDS;
      end
      S_EXEC: begin
        launch   = op_q == OP_QUERY && sys_q != SYS_UNSUPPORTED;
        do_write = op_q == OP_INSERT && !pool_full;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Beat capture: tdata from bit 0 is sys, sat, week, toe, millis, health,
  // source, ignore; tuser is the op
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= op_e'(s_axis_tuser[0]);
      sys_q  <= s_axis_tdata[1:0];
      sat_q  <= s_axis_tdata[7:2];
      week_q <= s_axis_tdata[20:8];
      ref_q  <= s_axis_tdata[40:21];
      qms_q  <= s_axis_tdata[70:41];
      unh_q  <= s_axis_tdata[71];
      src_q  <= s_axis_tdata[79:72];
      ign_q  <= s_axis_tdata[80];
    end
  end

  // Shared multiplier: millis * reciprocal, then week * 604800, then sum
  always_ff @(posedge clk_i) begin
    if (state_q == S_DIV || state_q == S_WEEK) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (state_q == S_WEEK) begin
      quot_q <= prod_q[RECIP_SHIFT +: QUOT_W];
    end
    if (state_q == S_SUM) begin
      abs_q <= prod_q[ABS_W-1:0] +
               ((op_q == OP_QUERY) ? ABS_W'(quot_q) : ABS_W'(ref_q));
    end
  end

  // Fill count
  always_comb begin
    count_d = count_q;
    if (do_write) count_d = count_q + COUNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Pending result
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      res_idx_q <= '0;
      res_age_q <= '0;
      if (op_q == OP_INSERT) begin
        res_status_q <= pool_full ? ST_FULL : ST_INSERTED;
        if (!pool_full) res_idx_q <= IDX_W'(count_q);
      end else begin
        res_status_q <= ST_NONE;
      end
    end else if (state_q == S_SCAN && tok_end_i.valid) begin
      if (tok_end_i.found) begin
        res_status_q <= ST_FOUND;
        res_idx_q    <= tok_end_i.idx;
        res_age_q    <= tok_end_i.age;
      end else begin
        res_status_q <= ST_NONE;
        res_idx_q    <= '0;
        res_age_q    <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_FINISH && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FINISH && out_free) begin
      out_status_q <= res_status_q;
      out_idx_q    <= res_idx_q;
      out_age_q    <= res_age_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_age_q, out_idx_q};
  assign m_axis_tuser  = out_status_q;

  // Cell row drive
  assign count_o = count_q;

  always_comb begin
    wr_o.en        = do_write;
    wr_o.sys       = sys_q;
    wr_o.sat       = sat_q;
    wr_o.rabs      = abs_q;
    wr_o.unhealthy = unh_q;
    wr_o.src       = src_q;

    query_o.sys    = sys_q;
    query_o.sat    = sat_q;
    query_o.qabs   = abs_q;
    query_o.src    = src_q;
    query_o.ignore = ign_q;

    launch_o       = '0;
    launch_o.valid = launch;
  end

  // Checks
  a_tok_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_end_i.valid |-> state_q == S_SCAN)
    else $error("token left the cell row outside a scan");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_COUNT)
    else $error("fill count beyond pool depth");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> (count_q < FULL_COUNT && !launch))
    else $error("record write into a full pool or during a launch");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_DIV)
    else $error("accepted beat did not start the sequence");

endmodule

// ===== sv/ephemeris_pool_select.sv =====
`timescale 1ns / 1ps
// Top level of the ephemeris pool selector: sequencer plus a row of record
// cells through which the best-record token runs. Depends on eps_pkg, eps_cell, eps_ctrl.
//
//  Channel  Dir  Fields (low bit first)
//  s_axis   in   tuser: op | tdata: system_id, sat_id, week_number, ref_seconds,
//                query_millis, unhealthy, source_tag, ignore_age
//  m_axis   out  tuser: status | tdata: entry_index, age_seconds
//
// Insert: time conversion on one shared multiplier, then the write, then the
// result is raised on m_axis_tvalid; the next beat is taken in the cycle after.
// Query: the same steps plus a scan in which the token crosses one cell per
// cycle. A query for the unsupported system skips the scan.
// One beat is in work at a time; the next is taken while a result waits in the
// output register. A stalled m_axis holds the sequencer in its last step.
// Reset clears the fill count but not the stored records; cells beyond the count are never matched.
module ephemeris_pool_select import eps_pkg::*; #(
  parameter int unsigned POOL_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sys[1:0] sat[7:2] week[20:8] toe[40:21] millis[70:41] unhealthy[71]
  // source[79:72] ignore_age[80], zero pad above
  input  logic [87:0] s_axis_tdata,
  // op[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // entry_index[5:0] age_seconds[36:6], zero pad above
  output logic [39:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser
);

  localparam int unsigned COUNT_W = $clog2(POOL_DEPTH + 1);

  logic [COUNT_W-1:0] count;
  wr_t                wr;
  query_t             query;
  token_t             tok [POOL_DEPTH+1];

  eps_ctrl #(
    .POOL_DEPTH (POOL_DEPTH),
    .COUNT_W    (COUNT_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .count_o       (count),
    .wr_o          (wr),
    .query_o       (query),
    .launch_o      (tok[0]),
    .tok_end_i     (tok[POOL_DEPTH])
  );

  // Row of record cells, token moves one cell per cycle
  for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
    eps_cell #(
      .CELL_IDX (i),
      .COUNT_W  (COUNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .count_i (count),
      .wr_i    (wr),
      .query_i (query),
      .tok_i   (tok[i]),
      .tok_o   (tok[i+1])
    );
  end

endmodule
